// ===== src/servo_bus_frame_codec_defines.svh =====
// Assertion macros for the RTL of the servo bus frame codec top level.
`ifndef SERVO_BUS_FRAME_CODEC_DEFINES_SVH
`define SERVO_BUS_FRAME_CODEC_DEFINES_SVH

`ifndef SYNTHESIS

`define SBFC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbfc: same-cycle check failed");

`define SBFC_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbfc: next-cycle check failed");

`else

`define SBFC_ASSERT_IMP(name, clk, rst, ante, cons)

`define SBFC_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== src/sbfc_pkg.sv =====
`default_nettype none

package sbfc_pkg;

   localparam int FRAME_MAX = 10;
   localparam int CNT_W = $clog2(FRAME_MAX + 1);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   localparam logic [2:0] KIND_MOVE = 3'd0;
   localparam logic [2:0] KIND_RESEND = 3'd1;
   localparam logic [2:0] KIND_LOAD = 3'd2;
   localparam logic [2:0] KIND_POS_REQ = 3'd3;
   localparam logic [2:0] KIND_RX_BYTE = 3'd4;

   localparam logic [1:0] OUT_TX = 2'd0;
   localparam logic [1:0] OUT_POS = 2'd1;
   localparam logic [1:0] OUT_CSUM_ERR = 2'd2;

   localparam logic [1:0] PHASE_HUNT = 2'd0;
   localparam logic [1:0] PHASE_LOW = 2'd1;
   localparam logic [1:0] PHASE_HIGH = 2'd2;
   localparam logic [1:0] PHASE_CSUM = 2'd3;

   localparam logic [7:0] HDR_BYTE = 8'h55;
   localparam logic [7:0] REPLY_MARK = 8'h1C;
   localparam logic [7:0] REPLY_SUM_BASE = 8'h21;

   localparam logic [7:0] LEN_MOVE = 8'd7;
   localparam logic [7:0] CMD_MOVE = 8'd1;
   localparam logic [7:0] LEN_LOAD = 8'd4;
   localparam logic [7:0] CMD_LOAD = 8'd31;
   localparam logic [7:0] LEN_POS = 8'd3;
   localparam logic [7:0] CMD_POS_READ = 8'd28;

   localparam logic signed [15:0] DEG_SPAN = 16'sd120;
   localparam logic [9:0] COUNTS_MAX = 10'd1000;
   localparam logic [12:0] COUNTS_PER_STEP = 13'd25;
   localparam logic [13:0] RECIP_6 = 14'd10923;
   localparam logic [17:0] REPLY_STEP = 18'd6;
   localparam logic [19:0] RECIP_25 = 20'd671089;

   typedef struct packed {
      logic [7:0] servo_id;
      logic signed [15:0] stored_angle;
      logic [1:0] phase;
      logic [7:0] low;
      logic [7:0] high;
   } sbfc_state_type;

   typedef struct packed {
      logic [FRAME_MAX-1:0][7:0] data;
      logic [CNT_W-1:0] cnt;
      logic [1:0] kind;
      logic signed [13:0] pos;
      logic angle_wr;
   } sbfc_frame_type;

endpackage

`default_nettype wire

// ===== src/sbfc_channels.sv =====
`default_nettype none

interface sbfc_req_if;
   logic valid;
   logic ready;
   logic [2:0] kind;
   logic signed [15:0] target_degrees;
   logic load_on;
   logic [7:0] rx_byte;

   modport source (output valid, kind, target_degrees, load_on, rx_byte, input ready);
   modport sink (input valid, kind, target_degrees, load_on, rx_byte, output ready);
endinterface

interface sbfc_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] out_kind;
   logic [7:0] tx_byte;
   logic last;
   logic signed [13:0] position_degrees;

   modport source (output valid, out_kind, tx_byte, last, position_degrees, input ready);
   modport sink (input valid, out_kind, tx_byte, last, position_degrees, output ready);
endinterface

interface sbfc_csr_if;
   logic valid;
   logic ready;
   logic [7:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== src/sbfc_frame_build.sv =====
`default_nettype none

module sbfc_frame_build import sbfc_pkg::*; (
   input logic [2:0] cmd_kind,
   input logic signed [15:0] cmd_degrees,
   input logic cmd_load_on,
   input logic [7:0] cmd_rx_byte,
   input sbfc_state_type cur,
   output sbfc_frame_type frame
);

   logic signed [15:0] move_deg;
   logic signed [15:0] move_sum;
   logic [12:0] move_scaled;
   logic [26:0] move_prod;
   logic [9:0] move_counts;
   logic [7:0] move_csum;
   logic [7:0] load_csum;
   logic [7:0] pos_csum;

   logic [15:0] rep_raw;
   logic [15:0] rep_mag;
   logic [17:0] rep_m;
   logic [37:0] rep_prod;
   logic [12:0] rep_q;
   logic signed [14:0] rep_sq;
   logic signed [14:0] rep_deg;
   logic [7:0] rep_sum;
   logic [7:0] rep_want;

   // Degrees to counts: (deg + 120) * 25 / 6 inside the span, saturated outside it.
   assign move_deg = (cmd_kind == KIND_MOVE) ? cmd_degrees : cur.stored_angle;
   assign move_sum = move_deg + DEG_SPAN;
   assign move_scaled = 13'(move_sum[7:0]) * COUNTS_PER_STEP;
   assign move_prod = 27'(move_scaled) * 27'(RECIP_6);

   always_comb begin
      if (move_deg < -DEG_SPAN) begin
         move_counts = '0;
      end else if (move_deg > DEG_SPAN) begin
         move_counts = COUNTS_MAX;
      end else begin
         move_counts = move_prod[25:16];
      end
   end

   assign move_csum = ~(cur.servo_id + LEN_MOVE + CMD_MOVE + move_counts[7:0]
                        + {6'd0, move_counts[9:8]});
   assign load_csum = ~(cur.servo_id + LEN_LOAD + CMD_LOAD + {7'd0, cmd_load_on});
   assign pos_csum = ~(cur.servo_id + LEN_POS + CMD_POS_READ);

   // Counts to degrees: |val| * 6 / 25 with the sign restored, then less 120.
   assign rep_raw = {cur.high, cur.low};
   assign rep_mag = rep_raw[15] ? (~rep_raw + 16'd1) : rep_raw;
   assign rep_m = 18'(rep_mag) * REPLY_STEP;
   assign rep_prod = 38'(rep_m) * 38'(RECIP_25);
   assign rep_q = rep_prod[36:24];
   assign rep_sq = rep_raw[15] ? -$signed({2'b00, rep_q}) : $signed({2'b00, rep_q});
   assign rep_deg = rep_sq - 15'(DEG_SPAN);
   assign rep_sum = cur.servo_id + REPLY_SUM_BASE + cur.low + cur.high;
   assign rep_want = ~rep_sum;

   always_comb begin
      frame = '0;
      frame.kind = OUT_TX;
      case (cmd_kind)
         KIND_MOVE, KIND_RESEND: begin
            frame.data[0] = HDR_BYTE;
            frame.data[1] = HDR_BYTE;
            frame.data[2] = cur.servo_id;
            frame.data[3] = LEN_MOVE;
            frame.data[4] = CMD_MOVE;
            frame.data[5] = move_counts[7:0];
            frame.data[6] = {6'd0, move_counts[9:8]};
            frame.data[9] = move_csum;
            frame.cnt = CNT_W'(10);
         end
         KIND_LOAD: begin
            frame.data[0] = HDR_BYTE;
            frame.data[1] = HDR_BYTE;
            frame.data[2] = cur.servo_id;
            frame.data[3] = LEN_LOAD;
            frame.data[4] = CMD_LOAD;
            frame.data[5] = {7'd0, cmd_load_on};
            frame.data[6] = load_csum;
            frame.cnt = CNT_W'(7);
         end
         KIND_POS_REQ: begin
            frame.data[0] = HDR_BYTE;
            frame.data[1] = HDR_BYTE;
            frame.data[2] = cur.servo_id;
            frame.data[3] = LEN_POS;
            frame.data[4] = CMD_POS_READ;
            frame.data[5] = pos_csum;
            frame.cnt = CNT_W'(6);
         end
         KIND_RX_BYTE: begin
            if (cur.phase == PHASE_CSUM) begin
               frame.cnt = CNT_ONE;
               if (cmd_rx_byte == rep_want) begin
                  frame.kind = OUT_POS;
                  frame.pos = rep_deg[13:0];
                  frame.angle_wr = 1'b1;
               end else begin
                  frame.kind = OUT_CSUM_ERR;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/servo_bus_frame_codec.sv =====
// Channel   Ports     Direction  Words
// request   req_bus   in         command or received bus byte, one per word
// response  rsp_bus   out        frame byte, decoded position or checksum error
// control   csr_bus   in         servo bus address
//
// A move or resend gives 10 words, a load/unload 7 and a position request 6,
// one word per cycle from a shifting frame buffer while not stalled; a received
// byte gives a word only as the checksum of a reply. Words go from the frame buffer to the
// response register. A new item is taken in the cycle the last word leaves the buffer.
// A stalled response holds its word; the frame buffer waits behind it.
// Reset is synchronous and sets the servo address to 1 and the scanner to hunting.
`default_nettype none

`include "servo_bus_frame_codec_defines.svh"

module servo_bus_frame_codec import sbfc_pkg::*; (
   input logic clock,
   input logic reset,
   sbfc_req_if.sink req_bus,
   sbfc_rsp_if.source rsp_bus,
   sbfc_csr_if.sink csr_bus
);

   logic out_free;
   logic emit;
   logic req_rdy;
   logic req_acc;

   logic [7:0] servo_id_ff, servo_id_in;
   logic signed [15:0] stored_angle_ff, stored_angle_in;
   logic [1:0] reply_phase_ff, reply_phase_in;
   logic [7:0] reply_low_ff, reply_low_in;
   logic [7:0] reply_high_ff, reply_high_in;

   logic [FRAME_MAX-1:0][7:0] frm_data_ff, frm_data_in;
   logic [CNT_W-1:0] frm_cnt_ff, frm_cnt_in;
   logic [1:0] frm_kind_ff, frm_kind_in;
   logic signed [13:0] frm_pos_ff, frm_pos_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic rsp_last_ff, rsp_last_in;
   logic signed [13:0] rsp_pos_ff, rsp_pos_in;

   sbfc_state_type cur;
   sbfc_frame_type bld;

   assign cur.servo_id = servo_id_ff;
   assign cur.stored_angle = stored_angle_ff;
   assign cur.phase = reply_phase_ff;
   assign cur.low = reply_low_ff;
   assign cur.high = reply_high_ff;

   sbfc_frame_build u_build (
      .cmd_kind (req_bus.kind),
      .cmd_degrees (req_bus.target_degrees),
      .cmd_load_on (req_bus.load_on),
      .cmd_rx_byte (req_bus.rx_byte),
      .cur (cur),
      .frame (bld)
   );

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign emit = (frm_cnt_ff != '0) && out_free;
   assign req_rdy = (frm_cnt_ff == '0) || ((frm_cnt_ff == CNT_ONE) && emit);
   assign req_acc = req_bus.valid && req_rdy;

   assign req_bus.ready = req_rdy;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.out_kind = rsp_kind_ff;
   assign rsp_bus.tx_byte = rsp_byte_ff;
   assign rsp_bus.last = rsp_last_ff;
   assign rsp_bus.position_degrees = rsp_pos_ff;

   always_comb begin
      servo_id_in = servo_id_ff;
      stored_angle_in = stored_angle_ff;
      reply_phase_in = reply_phase_ff;
      reply_low_in = reply_low_ff;
      reply_high_in = reply_high_ff;

      if (csr_bus.valid) begin
         servo_id_in = csr_bus.data;
      end

      if (req_acc) begin
         if (req_bus.kind == KIND_MOVE) begin
            stored_angle_in = req_bus.target_degrees;
         end
         if (bld.angle_wr) begin
            stored_angle_in = {{2{bld.pos[13]}}, bld.pos};
         end
         case (req_bus.kind)
            KIND_POS_REQ: begin
               reply_phase_in = PHASE_HUNT;
            end
            KIND_RX_BYTE: begin
               case (reply_phase_ff)
                  PHASE_HUNT: begin
                     if (req_bus.rx_byte == REPLY_MARK) begin
                        reply_phase_in = PHASE_LOW;
                     end
                  end
                  PHASE_LOW: begin
                     reply_low_in = req_bus.rx_byte;
                     reply_phase_in = PHASE_HIGH;
                  end
                  PHASE_HIGH: begin
                     reply_high_in = req_bus.rx_byte;
                     reply_phase_in = PHASE_CSUM;
                  end
                  default: begin
                     reply_phase_in = PHASE_HUNT;
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      frm_data_in = frm_data_ff;
      frm_cnt_in = frm_cnt_ff;
      frm_kind_in = frm_kind_ff;
      frm_pos_in = frm_pos_ff;

      if (emit) begin
         frm_data_in = {8'h00, frm_data_ff[FRAME_MAX-1:1]};
         frm_cnt_in = frm_cnt_ff - CNT_ONE;
      end

      if (req_acc && (bld.cnt != '0)) begin
         frm_data_in = bld.data;
         frm_cnt_in = bld.cnt;
         frm_kind_in = bld.kind;
         frm_pos_in = bld.pos;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      rsp_pos_in = rsp_pos_ff;

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in = frm_kind_ff;
         rsp_byte_in = frm_data_ff[0];
         rsp_last_in = (frm_cnt_ff == CNT_ONE);
         rsp_pos_in = frm_pos_ff;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         servo_id_ff <= 8'd1;
         stored_angle_ff <= '0;
         reply_phase_ff <= PHASE_HUNT;
         reply_low_ff <= '0;
         reply_high_ff <= '0;
         frm_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         servo_id_ff <= servo_id_in;
         stored_angle_ff <= stored_angle_in;
         reply_phase_ff <= reply_phase_in;
         reply_low_ff <= reply_low_in;
         reply_high_ff <= reply_high_in;
         frm_cnt_ff <= frm_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frm_data_ff <= frm_data_in;
      frm_kind_ff <= frm_kind_in;
      frm_pos_ff <= frm_pos_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_pos_ff <= rsp_pos_in;
   end

   `SBFC_ASSERT_IMP(a_frame_cnt_max, clock, reset, 1'b1, frm_cnt_ff <= CNT_W'(FRAME_MAX))
   `SBFC_ASSERT_IMP(a_accept_on_drain, clock, reset, req_acc && (frm_cnt_ff != '0), (frm_cnt_ff == CNT_ONE) && emit)
   `SBFC_ASSERT_NXT(a_pos_req_hunts, clock, reset, req_acc && (req_bus.kind == KIND_POS_REQ), reply_phase_ff == PHASE_HUNT)
   `SBFC_ASSERT_NXT(a_last_word_empties, clock, reset, emit && (frm_cnt_ff == CNT_ONE) && !req_acc, rsp_last_ff && (frm_cnt_ff == '0))

endmodule

`default_nettype wire
